/* hdl/rsp_pkg.sv */
// ----------------------------------------------------------------------------
// rsp_pkg: types and helpers for the rectangle subtract pieces unit
// Coordinate type, request and piece payloads, pipeline stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned NumPieces = 4;

  // piece slots, in emission order
  localparam int unsigned SlotTop    = 0;
  localparam int unsigned SlotBottom = 1;
  localparam int unsigned SlotRight  = 2;
  localparam int unsigned SlotLeft   = 3;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t rect_left;
    coord_t rect_top;
    coord_t rect_right;
    coord_t rect_bottom;
    coord_t mask_left;
    coord_t mask_top;
    coord_t mask_right;
    coord_t mask_bottom;
  } rsp_req_t;

  typedef struct packed {
    coord_t piece_left;
    coord_t piece_top;
    coord_t piece_right;
    coord_t piece_bottom;
    logic   last_piece;
  } rsp_piece_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  // one pipeline stage: working copy, mask, pieces cut so far
  typedef struct packed {
    box_t                 w;
    box_t                 m;
    box_t [NumPieces-1:0] pc;
    logic [NumPieces-1:0] pv;
    logic                 covered;
  } stage_t;

  function automatic logic has_area(input box_t p);
    return (p.l < p.r) && (p.t < p.b);
  endfunction

endpackage

`default_nettype wire

/* hdl/rect_subtract_pieces_unit.sv */
// ----------------------------------------------------------------------------
// rect_subtract_pieces_unit: rectangle minus mask, as up to four pieces
// Four-stage edge test pipeline followed by a piece emitter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i) carries one request:
//   a rectangle and a mask rectangle, right and bottom edges exclusive.
//   Output channel (out_valid_o / out_ready_i / piece_o) returns the visible
//   pieces in the order top, bottom, right, left; last_piece marks the final
//   piece of a request. A request with no visible area yields no piece.
//   Pipeline: stage 0 registers the request and tests the top edge, stages 1
//   to 3 test bottom, right and left and drop empty pieces, and the emitter
//   registers the kept pieces from stage 3 and presents them one by one.
//   Throughput: the emitter sends one piece per cycle while out_ready_i is
//   high, and loads the next request as the last piece of one is taken; a
//   request with no visible area passes through without holding it.
//   Reset clears all valid bits; the unit is ready at once afterwards.
//   When the receiver stalls the emitter holds its piece, the stages fill
//   behind it and in_ready_o drops once stage 0 is occupied and blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_subtract_pieces_unit
  import rsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire rsp_req_t   in_req_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output rsp_piece_t      piece_o
);

  stage_t s0_q, s1_q, s2_q, s3_q;
  stage_t s0_d, s1_d, s2_d, s3_d;
  logic   v0_q, v1_q, v2_q, v3_q;
  logic   rdy0, rdy1, rdy2, rdy3;

  box_t [NumPieces-1:0] em_pc_q;
  logic [NumPieces-1:0] em_keep_q, em_keep_d;
  logic [NumPieces-1:0] keep3;
  logic [NumPieces-1:0] sel;
  logic                 em_last;
  logic                 em_load;
  box_t                 em_box;

  // ---------------------------------------------------------------- stages
  always_comb begin
    s0_d        = '0;
    s0_d.w.l    = in_req_i.rect_left;
    s0_d.w.t    = in_req_i.rect_top;
    s0_d.w.r    = in_req_i.rect_right;
    s0_d.w.b    = in_req_i.rect_bottom;
    s0_d.m.l    = in_req_i.mask_left;
    s0_d.m.t    = in_req_i.mask_top;
    s0_d.m.r    = in_req_i.mask_right;
    s0_d.m.b    = in_req_i.mask_bottom;
  end

  // top edge test, plus the rectangle-inside-mask check
  always_comb begin
    s1_d         = s0_q;
    s1_d.covered = (s0_q.m.l <= s0_q.w.l) && (s0_q.w.r <= s0_q.m.r) &&
                   (s0_q.m.t <= s0_q.w.t) && (s0_q.w.b <= s0_q.m.b);
    if ((s0_q.w.t <= s0_q.m.t) && (s0_q.m.t <= s0_q.w.b) &&
        (s0_q.w.l <= s0_q.m.r) && (s0_q.w.r >= s0_q.m.l)) begin
      s1_d.pc[SlotTop]   = s0_q.w;
      s1_d.pc[SlotTop].b = s0_q.m.t;
      s1_d.pv[SlotTop]   = 1'b1;
      s1_d.w.t           = s0_q.m.t;
    end
  end

  // bottom edge test
  always_comb begin
    s2_d = s1_q;
    if ((s1_q.w.b >= s1_q.m.b) && (s1_q.m.b >= s1_q.w.t) &&
        (s1_q.w.r >= s1_q.m.l) && (s1_q.w.l <= s1_q.m.r)) begin
      s2_d.pc[SlotBottom]   = s1_q.w;
      s2_d.pc[SlotBottom].t = s1_q.m.b;
      s2_d.pv[SlotBottom]   = 1'b1;
      s2_d.w.b              = s1_q.m.b;
    end
  end

  // right edge test
  always_comb begin
    s3_d = s2_q;
    if ((s2_q.w.r >= s2_q.m.r) && (s2_q.m.r >= s2_q.w.l) &&
        (s2_q.w.t <= s2_q.m.b) && (s2_q.w.b >= s2_q.m.t)) begin
      s3_d.pc[SlotRight]   = s2_q.w;
      s3_d.pc[SlotRight].l = s2_q.m.r;
      s3_d.pv[SlotRight]   = 1'b1;
      s3_d.w.r             = s2_q.m.r;
    end
  end

  // left edge test, disjoint fallback, empty-piece drop
  stage_t s4;
  always_comb begin
    s4 = s3_q;
    if ((s3_q.w.l <= s3_q.m.l) && (s3_q.m.l <= s3_q.w.r) &&
        (s3_q.w.b >= s3_q.m.t) && (s3_q.w.t <= s3_q.m.b)) begin
      s4.pc[SlotLeft]   = s3_q.w;
      s4.pc[SlotLeft].r = s3_q.m.l;
      s4.pv[SlotLeft]   = 1'b1;
    end
    // nothing fired: working copy is still the original rectangle
    if (s4.pv == '0) begin
      s4.pc[SlotTop] = s3_q.w;
      s4.pv[SlotTop] = 1'b1;
    end
    for (int k = 0; k < NumPieces; k++) begin
      keep3[k] = s4.pv[k] && has_area(s4.pc[k]) && !s3_q.covered;
    end
  end

  // ------------------------------------------------------------ flow control
  assign rdy3       = !v3_q || em_load;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) s0_q <= s0_d;
    if (rdy1 && v0_q)       s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
  end

  // ---------------------------------------------------------------- emitter
  assign sel     = em_keep_q & (~em_keep_q + 1'b1);
  assign em_last = (em_keep_q & ~sel) == '0;
  assign em_load = (em_keep_q == '0) || (out_ready_i && em_last);

  always_comb begin
    case (sel)
      4'b0010: em_box = em_pc_q[SlotBottom];
      4'b0100: em_box = em_pc_q[SlotRight];
      4'b1000: em_box = em_pc_q[SlotLeft];
      default: em_box = em_pc_q[SlotTop];
    endcase
  end

  always_comb begin
    em_keep_d = em_keep_q;
    if (em_load) begin
      em_keep_d = v3_q ? keep3 : '0;
    end else if (out_ready_i) begin
      em_keep_d = em_keep_q & ~sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_keep_q <= '0;
    end else begin
      em_keep_q <= em_keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_load && v3_q) em_pc_q <= s4.pc;
  end

  assign out_valid_o          = em_keep_q != '0;
  assign piece_o.piece_left   = em_box.l;
  assign piece_o.piece_top    = em_box.t;
  assign piece_o.piece_right  = em_box.r;
  assign piece_o.piece_bottom = em_box.b;
  assign piece_o.last_piece   = em_last;

`ifndef SYNTHESIS
  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy3 |=> v3_q && $stable(s3_q))
    else $error("stage 3 lost or changed a stalled request");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v0_q)
    else $error("accepted request did not reach stage 0");

  a_piece_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (piece_o.piece_left < piece_o.piece_right) &&
                    (piece_o.piece_top < piece_o.piece_bottom))
    else $error("emitted piece has no area");

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(sel))
    else $error("emitter slot select not one-hot");
`endif

endmodule

`default_nettype wire
